[design/zrvd_pkg.sv]
// zero-run visibility decompressor shared types and constants
package zrvd_pkg;

  localparam int MAX_ROW_BYTES_DEF = 256;
  localparam int LEAF_W            = 12;
  localparam int ROW_FULL_W        = 10;
  localparam int KIND_W            = 2;
  localparam int BYTE_W            = 8;
  localparam int IDX_W             = 5;
  localparam int WORD_W            = 64;
  localparam int VALID_W           = 4;
  localparam int OUT_DATA_W        = 80;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESTART = 2'd0,
    KIND_NOVIS   = 2'd1,
    KIND_BYTE    = 2'd2,
    KIND_UNUSED  = 2'd3
  } zrvd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FILL = 3'b100
  } zrvd_state_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic fill;
    logic load;
  } zrvd_cmd_t;

  typedef struct packed {
    logic acc_emit;
    logic go_run;
    logic go_fill;
    logic run_emit;
    logic run_end;
    logic fill_end;
  } zrvd_sts_t;

endpackage

[design/zrvd_ctrl.sv]
// zero-run visibility decompressor control state machine
module zrvd_ctrl
  import zrvd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  zrvd_sts_t sts,
  output zrvd_cmd_t cmd
);

  zrvd_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && slot_free;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && in_tready;
    cmd.step   = ((state_r == ST_RUN) || (state_r == ST_FILL)) && slot_free;
    cmd.fill   = (state_r == ST_FILL);
    cmd.load   = (cmd.accept && sts.acc_emit) ||
                 (cmd.step && (cmd.fill || sts.run_emit));
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.go_run) begin
          state_nxt = ST_RUN;
        end else if (cmd.accept && sts.go_fill) begin
          state_nxt = ST_FILL;
        end
      end
      ST_RUN: begin
        if (cmd.step && sts.run_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (cmd.step && sts.fill_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/zrvd_dp.sv]
// zero-run visibility decompressor row state, run and fill datapath
module zrvd_dp
  import zrvd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [LEAF_W-1:0]  cfg_data,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [BYTE_W-1:0]  in_byte,
  input  zrvd_cmd_t          cmd,
  output zrvd_sts_t          sts,
  output logic [IDX_W-1:0]   word_index,
  output logic [WORD_W-1:0]  row_word,
  output logic [VALID_W-1:0] valid_bytes,
  output logic               row_done,
  output logic               run_last
);

  localparam int BW_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int CMP_W = ((BW_W > BYTE_W) ? BW_W : BYTE_W) + 1;

  logic [BW_W-1:0]   row_len_r;
  logic [BW_W-1:0]   bw_r, bw_nxt;
  logic              expect_r, expect_nxt;
  logic [WORD_W-1:0] partial_r, partial_nxt;
  logic              complete_r, complete_nxt;
  logic [BYTE_W-1:0] rem_r, rem_nxt;

  logic [IDX_W-1:0]   word_index_r;
  logic [WORD_W-1:0]  row_word_r;
  logic [VALID_W-1:0] valid_bytes_r;
  logic               row_done_r;
  logic               run_last_r;

  logic [ROW_FULL_W-1:0] cfg_row_full;
  logic [BW_W-1:0]       cfg_row;

  logic [2:0]        pos;
  logic [BW_W-1:0]   left;
  logic              row_zero;

  // literal byte
  logic              lit_stale;
  logic [BW_W-1:0]   lit_bw_n;
  logic              lit_done;
  logic              lit_emit;
  logic [WORD_W-1:0] lit_word;
  logic              byte_live;

  // zero run chunk
  logic [VALID_W-1:0] room;
  logic [CMP_W-1:0]   rem_c, room_c, left_c, chunk_c;
  logic [VALID_W-1:0] chunk;
  logic [BW_W-1:0]    run_bw_n, run_bw_m1;
  logic               run_full, run_done, run_emit, run_more, run_end;
  logic [BYTE_W-1:0]  run_rem_n;

  // no-visibility fill
  logic [VALID_W-1:0] fill_valid;
  logic               fill_done;
  logic [WORD_W-1:0]  fill_word;

  logic [IDX_W-1:0]   res_idx;
  logic [WORD_W-1:0]  res_word;
  logic [VALID_W-1:0] res_valid;
  logic               res_done, res_last;

  assign cfg_row_full = ROW_FULL_W'(({1'b0, cfg_data} + 13'd7) >> 3);
  assign cfg_row      = (cfg_row_full > ROW_FULL_W'(MAX_ROW_BYTES)) ?
                        BW_W'(MAX_ROW_BYTES) : BW_W'(cfg_row_full);

  assign pos      = bw_r[2:0];
  assign left     = row_len_r - bw_r;
  assign row_zero = (row_len_r == '0);

  assign lit_stale = !complete_r && (bw_r >= row_len_r);
  assign lit_bw_n  = bw_r + BW_W'(1);
  assign lit_done  = (lit_bw_n == row_len_r);
  assign lit_emit  = (pos == 3'd7) || lit_done;
  assign lit_word  = partial_r | (WORD_W'(in_byte) << {pos, 3'b000});
  assign byte_live = (zrvd_kind_t'(in_kind) == KIND_BYTE) && !complete_r && !lit_stale;

  assign room    = VALID_W'(8) - VALID_W'(pos);
  assign rem_c   = CMP_W'(rem_r);
  assign room_c  = CMP_W'(room);
  assign left_c  = CMP_W'(left);
  always_comb begin
    chunk_c = rem_c;
    if (room_c < chunk_c) begin
      chunk_c = room_c;
    end
    if (left_c < chunk_c) begin
      chunk_c = left_c;
    end
  end
  assign chunk     = chunk_c[VALID_W-1:0];
  assign run_bw_n  = bw_r + BW_W'(chunk);
  assign run_bw_m1 = run_bw_n - BW_W'(1);
  assign run_full  = (chunk == room);
  assign run_done  = (run_bw_n == row_len_r);
  assign run_emit  = run_full || run_done;
  assign run_rem_n = rem_r - BYTE_W'(chunk);
  assign run_more  = (run_rem_n >= BYTE_W'(8)) ||
                     ((CMP_W'(run_bw_n) + CMP_W'(run_rem_n)) >= CMP_W'(row_len_r));
  assign run_end   = run_done || (run_rem_n == '0);

  assign fill_done  = (left <= BW_W'(8));
  assign fill_valid = fill_done ? VALID_W'(left) : VALID_W'(8);
  assign fill_word  = {WORD_W{1'b1}} >> (7'd64 - {fill_valid, 3'b000});

  always_comb begin
    sts.acc_emit = byte_live && !expect_r && (in_byte != '0) && lit_emit;
    sts.go_run   = byte_live && expect_r && (in_byte != '0);
    sts.go_fill  = (zrvd_kind_t'(in_kind) == KIND_NOVIS) && !row_zero;
    sts.run_emit = run_emit;
    sts.run_end  = run_end;
    sts.fill_end = fill_done;
  end

  always_comb begin
    bw_nxt       = bw_r;
    expect_nxt   = expect_r;
    partial_nxt  = partial_r;
    complete_nxt = complete_r;
    rem_nxt      = rem_r;

    if (cmd.accept) begin
      case (zrvd_kind_t'(in_kind))
        KIND_RESTART: begin
          bw_nxt       = '0;
          expect_nxt   = 1'b0;
          partial_nxt  = '0;
          complete_nxt = row_zero;
        end
        KIND_NOVIS: begin
          bw_nxt       = '0;
          expect_nxt   = 1'b0;
          partial_nxt  = '0;
          complete_nxt = 1'b1;
        end
        KIND_BYTE: begin
          if (lit_stale) begin
            complete_nxt = 1'b1;
            expect_nxt   = 1'b0;
            partial_nxt  = '0;
          end else if (!complete_r) begin
            if (expect_r) begin
              expect_nxt = 1'b0;
              rem_nxt    = in_byte;
            end else if (in_byte != '0) begin
              bw_nxt       = lit_bw_n;
              partial_nxt  = lit_emit ? '0 : lit_word;
              if (lit_done) begin
                complete_nxt = 1'b1;
              end
            end else begin
              expect_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.step && cmd.fill) begin
      bw_nxt = fill_done ? '0 : bw_r + BW_W'(8);
    end else if (cmd.step) begin
      bw_nxt  = run_bw_n;
      rem_nxt = run_rem_n;
      if (run_emit) begin
        partial_nxt = '0;
      end
      if (run_done) begin
        complete_nxt = 1'b1;
        expect_nxt   = 1'b0;
      end
    end
  end

  always_comb begin
    if (cmd.step && cmd.fill) begin
      res_idx   = IDX_W'(bw_r >> 3);
      res_word  = fill_word;
      res_valid = fill_valid;
      res_done  = fill_done;
      res_last  = fill_done;
    end else if (cmd.step) begin
      res_idx   = IDX_W'(run_bw_m1 >> 3);
      res_word  = partial_r;
      res_valid = VALID_W'(run_bw_m1[2:0]) + VALID_W'(1);
      res_done  = run_done;
      res_last  = run_end || !run_more;
    end else begin
      res_idx   = IDX_W'(bw_r >> 3);
      res_word  = lit_word;
      res_valid = VALID_W'(pos) + VALID_W'(1);
      res_done  = lit_done;
      res_last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r  <= BW_W'(1);
      bw_r       <= '0;
      expect_r   <= 1'b0;
      partial_r  <= '0;
      complete_r <= 1'b1;
      rem_r      <= '0;
    end else begin
      if (cfg_valid) begin
        row_len_r <= cfg_row;
      end
      bw_r       <= bw_nxt;
      expect_r   <= expect_nxt;
      partial_r  <= partial_nxt;
      complete_r <= complete_nxt;
      rem_r      <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_index_r  <= res_idx;
      row_word_r    <= res_word;
      valid_bytes_r <= res_valid;
      row_done_r    <= res_done;
      run_last_r    <= res_last;
    end
  end

  assign word_index  = word_index_r;
  assign row_word    = row_word_r;
  assign valid_bytes = valid_bytes_r;
  assign row_done    = row_done_r;
  assign run_last    = run_last_r;

endmodule

[design/zero_run_visibility_decompressor.sv]
// zero-run visibility decompressor top level
//
//  channel | ports                    | payload
//  --------+--------------------------+------------------------------------------
//  cfg     | cfg_valid/ready/data     | leaf_count [11:0]
//  in      | in_tvalid/tready/tdata   | tdata: data_byte; tuser: kind
//  out     | out_tvalid/tready/tdata  | tdata: word_index,row_word,valid_bytes,
//          |                          | row_done; tlast: run_last
//
// literal, count, restart and unused items are each accepted in the idle state
// a zero run emits its output words from the run state; its last step may emit no word
// a no-visibility row emits one all-ones output word per fill step, up to 32
// input stalls while a run or fill is active or the output word is held
// synchronous active-low reset; row starts complete with leaf_count 1
module zero_run_visibility_decompressor
  import zrvd_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEAF_W-1:0]     cfg_data,   // leaf_count
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // data_byte
  input  logic [KIND_W-1:0]     in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // word_index, row_word, valid_bytes, row_done, pad
  output logic                  out_tlast
);

  zrvd_cmd_t          cmd;
  zrvd_sts_t          sts;
  logic [IDX_W-1:0]   word_index;
  logic [WORD_W-1:0]  row_word;
  logic [VALID_W-1:0] valid_bytes;
  logic               row_done;

  assign cfg_ready = 1'b1;
  assign out_tdata = {6'd0, row_done, valid_bytes, row_word, word_index};

  zrvd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  zrvd_dp #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_kind     (in_tuser),
    .in_byte     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .word_index  (word_index),
    .row_word    (row_word),
    .valid_bytes (valid_bytes),
    .row_done    (row_done),
    .run_last    (out_tlast)
  );

endmodule

[design/zrvd_checker.sv]
// zero-run visibility decompressor port checker and bind
module zrvd_checker
  import zrvd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // row end is always the last word of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[73] |-> out_tlast)
    else $error("row_done without tlast");

  a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[72:69] != 4'd0) && (out_tdata[72:69] <= 4'd8))
    else $error("valid_bytes out of range");

  // a held word blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

endmodule

bind zero_run_visibility_decompressor zrvd_checker u_zrvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
